// File: hw/rtl/mbrf_pkg.sv
// mbrf_pkg: shared types, constants and functions of the request framer
// depends on nothing; imported by mbrf_core and modbus_rtu_request_framer_unit
package mbrf_pkg;

	localparam logic [7:0]  FC_WRITE_COILS = 8'd15;
	localparam logic [7:0]  FC_WRITE_REGS  = 8'd16;
	localparam logic [7:0]  BCAST_ADDR     = 8'd0;
	localparam logic [8:0]  LEN_FIXED      = 9'd8;
	localparam logic [8:0]  LEN_MULTI_BASE = 9'd9;
	localparam logic [8:0]  POS_ADDR       = 9'd0;
	localparam logic [8:0]  POS_FUNC       = 9'd1;
	localparam logic [8:0]  POS_QTY_HI     = 9'd4;
	localparam logic [8:0]  POS_QTY_LO     = 9'd5;
	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [15:0] CRC_POLY       = 16'hA001;
	localparam logic [7:0]  OWN_ADDR_RESET = 8'd1;

	typedef enum logic [2:0] {
		EV_PROGRESS = 3'd0,
		EV_GOOD     = 3'd1,
		EV_BAD_ADDR = 3'd2,
		EV_BAD_FUNC = 3'd3,
		EV_BAD_CRC  = 3'd4
	} mbrf_event_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [8:0]  byte_position;
		mbrf_event_t event_code;
		logic        frame_done;
		logic        is_broadcast;
	} mbrf_result_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'd0, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	function automatic logic function_known(input logic [7:0] fc);
		return (fc >= 8'd1 && fc <= 8'd6) || fc == FC_WRITE_COILS || fc == FC_WRITE_REGS;
	endfunction

endpackage

// File: hw/rtl/mbrf_core.sv
// mbrf_core: candidate frame state, crc update and event decision for one byte
// depends on mbrf_pkg
module mbrf_core import mbrf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   rx_byte,
	input  logic [7:0]   own_address,
	output mbrf_result_t result
);

	logic [8:0]  pos_q;
	logic [15:0] crc_q;
	logic [7:0]  func_q;
	logic [7:0]  qty_hi_q;
	logic [8:0]  len_q;
	logic        bcast_q;
	logic [7:0]  crc_lo_q;

	logic [15:0] crc_n;
	logic [7:0]  func_n;
	logic [7:0]  qty_hi_n;
	logic [8:0]  len_n;
	logic        bcast_n;
	logic [7:0]  crc_lo_n;
	logic        done;
	logic        bcast;
	mbrf_event_t ev;
	logic [16:0] qty_sum;
	logic [7:0]  count;
	logic [9:0]  pos_plus2;
	logic [15:0] got;

	always_comb begin
		crc_n     = crc_q;
		func_n    = func_q;
		qty_hi_n  = qty_hi_q;
		len_n     = len_q;
		bcast_n   = bcast_q;
		crc_lo_n  = crc_lo_q;
		done      = 1'b0;
		ev        = EV_PROGRESS;
		bcast     = bcast_q;
		qty_sum   = {1'b0, qty_hi_q, rx_byte} + 17'd7;
		count     = 8'd0;
		pos_plus2 = {1'b0, pos_q} + 10'd2;
		got       = {rx_byte, crc_lo_q};
		if (pos_q == POS_ADDR) begin
			bcast = (rx_byte == BCAST_ADDR);
			if (rx_byte != own_address && rx_byte != BCAST_ADDR) begin
				ev   = EV_BAD_ADDR;
				done = 1'b1;
			end else begin
				bcast_n = bcast;
				crc_n   = crc_update(crc_q, rx_byte);
			end
		end else begin
			if (pos_q == POS_FUNC) begin
				if (!function_known(rx_byte)) begin
					ev   = EV_BAD_FUNC;
					done = 1'b1;
				end else begin
					func_n = rx_byte;
					len_n  = LEN_FIXED;
				end
			end else if (pos_q == POS_QTY_HI) begin
				qty_hi_n = rx_byte;
			end else if (pos_q == POS_QTY_LO) begin
				if (func_q == FC_WRITE_COILS) begin
					count = qty_sum[10:3];
					len_n = LEN_MULTI_BASE + {1'b0, count};
				end else if (func_q == FC_WRITE_REGS) begin
					count = {rx_byte[6:0], 1'b0};
					len_n = LEN_MULTI_BASE + {1'b0, count};
				end else begin
					len_n = LEN_FIXED;
				end
			end
			if (!done) begin
				if (pos_plus2 < {1'b0, len_n}) begin
					crc_n = crc_update(crc_q, rx_byte);
				end else if (pos_plus2 == {1'b0, len_n}) begin
					crc_lo_n = rx_byte;
				end else begin
					ev   = (got == crc_q) ? EV_GOOD : EV_BAD_CRC;
					done = 1'b1;
				end
			end
		end
		result.data_byte     = rx_byte;
		result.byte_position = pos_q;
		result.event_code    = ev;
		result.frame_done    = done;
		result.is_broadcast  = bcast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_ADDR;
			crc_q    <= CRC_INIT;
			func_q   <= 8'd0;
			qty_hi_q <= 8'd0;
			len_q    <= LEN_FIXED;
			bcast_q  <= 1'b0;
			crc_lo_q <= 8'd0;
		end else if (step) begin
			if (done) begin
				pos_q    <= POS_ADDR;
				crc_q    <= CRC_INIT;
				func_q   <= 8'd0;
				qty_hi_q <= 8'd0;
				len_q    <= LEN_FIXED;
				bcast_q  <= 1'b0;
				crc_lo_q <= 8'd0;
			end else begin
				pos_q    <= pos_q + 9'd1;
				crc_q    <= crc_n;
				func_q   <= func_n;
				qty_hi_q <= qty_hi_n;
				len_q    <= len_n;
				bcast_q  <= bcast_n;
				crc_lo_q <= crc_lo_n;
			end
		end
	end

endmodule

// File: hw/rtl/modbus_rtu_request_framer_unit.sv
// modbus_rtu_request_framer_unit: top level with input register, result register
// and slave address register; depends on mbrf_pkg and mbrf_core
//
// Modbus RTU request framer. Received bytes enter one per transfer and each one
// comes back as one result: the byte, its position in the current candidate frame,
// an event (in progress, good frame, bad address, bad function, bad crc), a done
// flag and the broadcast flag. The block takes one byte every cycle while results
// are taken. A byte is held in the input register and its result in the result
// register before the result shows on the output. The byte-wise crc-16 update
// and length compare sit between the two registers. own_address resets to 1 and
// is written through cfg_write_en and cfg_write_data; the user must write it only
// while no byte is in flight, as the block does not enforce this.
module modbus_rtu_request_framer_unit import mbrf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write_en,
	input  logic [7:0] cfg_write_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_byte,
	output logic [8:0] byte_position,
	output logic [2:0] event_code,
	output logic       frame_done,
	output logic       is_broadcast
);

	logic [7:0]   own_address_q;
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         valid_s2;
	mbrf_result_t result_s2;
	mbrf_result_t core_result;
	logic         advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= OWN_ADDR_RESET;
		end else if (cfg_write_en) begin
			own_address_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
		if (advance) begin
			result_s2 <= core_result;
		end
	end

	mbrf_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.rx_byte     (byte_s1),
		.own_address (own_address_q),
		.result      (core_result)
	);

	assign out_valid     = valid_s2;
	assign data_byte     = result_s2.data_byte;
	assign byte_position = result_s2.byte_position;
	assign event_code    = result_s2.event_code;
	assign frame_done    = result_s2.frame_done;
	assign is_broadcast  = result_s2.is_broadcast;

	a_done_has_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_done == (event_code != EV_PROGRESS)))
		else $error("frame_done and event_code disagree");

	a_addr_bcast: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_position == POS_ADDR && event_code != EV_BAD_ADDR
		|-> (is_broadcast == (data_byte == BCAST_ADDR)))
		else $error("broadcast flag wrong on address byte");

	a_bad_func_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_code == EV_BAD_FUNC |-> byte_position == POS_FUNC)
		else $error("bad function reported off the function byte");

	a_good_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_code == EV_GOOD || event_code == EV_BAD_CRC)
		|-> byte_position >= (LEN_FIXED - 9'd1))
		else $error("frame ended shorter than minimum length");

endmodule
